// ----- hw/rtl/lma_pkg.sv -----
// ----------------------------------------------------------------------------
// lma_pkg
// Shared types and constants for the line moving average block.
// ----------------------------------------------------------------------------
package lma_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int DIV_W       = 4;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  // floor(2^24 / d); entry 0 is never used (divisor is at least 1)
  localparam logic [RECIP_W-1:0] RECIP_TBL [16] = '{
    25'd16777216, 25'd16777216, 25'd8388608, 25'd5592405,
    25'd4194304,  25'd3355443,  25'd2796202, 25'd2396745,
    25'd2097152,  25'd1864135,  25'd1677721, 25'd1525201,
    25'd1398101,  25'd1290555,  25'd1198372, 25'd1118481
  };

  // tag that travels with each pipeline stage
  typedef struct packed {
    logic valid;
    logic last;
  } lma_tag_t;

  // pipeline control from the top level
  typedef struct packed {
    logic advance;
    logic clear;
  } lma_ctrl_t;

endpackage

// ----- hw/rtl/line_moving_average.sv -----
// ----------------------------------------------------------------------------
// line_moving_average
// Per-column boxcar mean of a line-camera spectrum over recent lines.
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// in_       input      in_valid/in_stall    in_sample[15:0], in_line_end
// out_      output     out_valid/out_stall  out_average[15:0], out_last
// cfg_      input      cfg_valid/cfg_ready  cfg_avg_size[3:0]
//
// One sample per clock while in_stall is low; stage s5 is the output register.
// The whole pipeline moves together and freezes while out_stall holds a result.
// After reset and after every cfg_ transaction a sweep zeroes the
// MAX_LINES*LINE_WIDTH line store entries (one per cycle) and the column sums;
// in_stall stays high until it ends. cfg_ready is always high.
// ----------------------------------------------------------------------------
module line_moving_average import lma_pkg::*; #(
  parameter int LINE_WIDTH = 2048,
  parameter int MAX_LINES  = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                in_line_end,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SAMPLE_W-1:0] out_average,
  output logic                out_last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [DIV_W-1:0]    cfg_avg_size
);

  localparam int SUM_W = SAMPLE_W + $clog2(MAX_LINES);

  logic [DIV_W-1:0]   div_r, div_nxt;
  logic [RECIP_W-1:0] recip_r;
  logic               cfg_wr;
  logic               busy;
  lma_ctrl_t          ctrl;
  lma_tag_t           s2_tag;
  logic [SUM_W-1:0]   s2_sum;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    div_nxt = cfg_avg_size;
    if (div_nxt == '0) begin
      div_nxt = DIV_W'(1);
    end
    if (32'(div_nxt) > MAX_LINES) begin
      div_nxt = DIV_W'(MAX_LINES);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r   <= DIV_W'(1);
      recip_r <= RECIP_TBL[1];
    end else if (cfg_wr) begin
      div_r   <= div_nxt;
      recip_r <= RECIP_TBL[div_nxt];
    end
  end

  assign ctrl.advance = !out_valid || !out_stall;
  assign ctrl.clear   = cfg_wr;
  assign in_stall     = busy || !ctrl.advance;

  lma_accum #(
    .LINE_WIDTH (LINE_WIDTH),
    .MAX_LINES  (MAX_LINES),
    .SUM_W      (SUM_W)
  ) u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .div         (div_r),
    .in_valid    (in_valid),
    .in_sample   (in_sample),
    .in_line_end (in_line_end),
    .busy        (busy),
    .s2_tag      (s2_tag),
    .s2_sum      (s2_sum)
  );

  lma_div #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (ctrl.advance),
    .div         (div_r),
    .recip       (recip_r),
    .s2_tag      (s2_tag),
    .s2_sum      (s2_sum),
    .out_valid   (out_valid),
    .out_average (out_average),
    .out_last    (out_last)
  );

endmodule

// ----- hw/rtl/lma_accum.sv -----
// ----------------------------------------------------------------------------
// lma_accum
// Ring of line stores, per-column running sums and the clearing sweep.
// ----------------------------------------------------------------------------
module lma_accum import lma_pkg::*; #(
  parameter int LINE_WIDTH = 2048,
  parameter int MAX_LINES  = 8,
  parameter int SUM_W      = SAMPLE_W + $clog2(MAX_LINES)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lma_ctrl_t           ctrl,
  input  logic [DIV_W-1:0]    div,
  input  logic                in_valid,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                in_line_end,
  output logic                busy,
  output lma_tag_t            s2_tag,
  output logic [SUM_W-1:0]    s2_sum
);

  localparam int COL_W    = $clog2(LINE_WIDTH);
  localparam int SLOT_W   = $clog2(MAX_LINES);
  localparam int LS_DEPTH = MAX_LINES * LINE_WIDTH;
  localparam int LS_AW    = $clog2(LS_DEPTH);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(LINE_WIDTH - 1);
  localparam logic [LS_AW-1:0] LS_LAST  = LS_AW'(LS_DEPTH - 1);
  localparam logic [LS_AW-1:0] LW_STEP  = LS_AW'(LINE_WIDTH);

  logic [SAMPLE_W-1:0] line_store [LS_DEPTH];
  logic [SUM_W-1:0]    column_sum [LINE_WIDTH];

  // write pointers
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [LS_AW-1:0]  base_r, base_nxt;
  logic [LS_AW-1:0]  addr_r, addr_nxt;

  logic             clr_active_r;
  logic [LS_AW-1:0] clr_addr_r;

  // stage 1: memory read data
  lma_tag_t            s1_tag_r;
  logic [COL_W-1:0]    s1_col_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic [SAMPLE_W-1:0] rd_old_r;
  logic [SUM_W-1:0]    rd_sum_r;

  // stage 2: updated sum
  lma_tag_t         s2_tag_r;
  logic [COL_W-1:0] s2_col_r;
  logic [SUM_W-1:0] s2_sum_r;

  logic             acc;
  logic             slot_wrap;
  logic [SUM_W-1:0] base_sum;
  logic [SUM_W-1:0] sum_nxt;

  assign busy = clr_active_r;
  assign acc  = in_valid && ctrl.advance && !clr_active_r;

  assign slot_wrap = (32'(slot_r) + 32'd1) >= 32'(div);

  always_comb begin
    col_nxt  = col_r;
    slot_nxt = slot_r;
    base_nxt = base_r;
    addr_nxt = addr_r;
    if (in_line_end) begin
      col_nxt = '0;
      if (slot_wrap) begin
        slot_nxt = '0;
        base_nxt = '0;
      end else begin
        slot_nxt = slot_r + SLOT_W'(1);
        base_nxt = base_r + LW_STEP;
      end
      addr_nxt = base_nxt;
    end else if (col_r == COL_LAST) begin
      col_nxt  = '0;
      addr_nxt = base_r;
    end else begin
      col_nxt  = col_r + COL_W'(1);
      addr_nxt = addr_r + LS_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      slot_r       <= '0;
      base_r       <= '0;
      addr_r       <= '0;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (ctrl.clear) begin
      col_r        <= '0;
      slot_r       <= '0;
      base_r       <= '0;
      addr_r       <= '0;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else begin
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + LS_AW'(1);
        if (clr_addr_r == LS_LAST) begin
          clr_active_r <= 1'b0;
        end
      end
      if (acc) begin
        col_r  <= col_nxt;
        slot_r <= slot_nxt;
        base_r <= base_nxt;
        addr_r <= addr_nxt;
      end
    end
  end

  // line store: old value is read in the same cycle the new sample lands
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_old_r <= line_store[addr_r];
    end
    if (clr_active_r) begin
      line_store[clr_addr_r] <= '0;
    end else if (acc) begin
      line_store[addr_r] <= in_sample;
    end
  end

  // the previous item may have just written this column
  assign base_sum = (s2_tag_r.valid && (s2_col_r == s1_col_r)) ? s2_sum_r : rd_sum_r;
  assign sum_nxt  = base_sum - SUM_W'(rd_old_r) + SUM_W'(s1_sample_r);

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_sum_r <= column_sum[col_r];
    end
    if (clr_active_r) begin
      if (32'(clr_addr_r) < LINE_WIDTH) begin
        column_sum[clr_addr_r[COL_W-1:0]] <= '0;
      end
    end else if (ctrl.advance && s1_tag_r.valid) begin
      column_sum[s1_col_r] <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
      s2_tag_r <= '0;
    end else if (ctrl.advance) begin
      s1_tag_r.valid <= acc;
      s1_tag_r.last  <= in_line_end;
      s2_tag_r       <= s1_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_col_r    <= col_r;
      s1_sample_r <= in_sample;
    end
    if (ctrl.advance) begin
      s2_col_r <= s1_col_r;
      s2_sum_r <= sum_nxt;
    end
  end

  assign s2_tag = s2_tag_r;
  assign s2_sum = s2_sum_r;

endmodule

// ----- hw/rtl/lma_div.sv -----
// ----------------------------------------------------------------------------
// lma_div
// Pipelined divide of the column sum by the line count via reciprocal.
// ----------------------------------------------------------------------------
module lma_div import lma_pkg::*; #(
  parameter int SUM_W = 19
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic [DIV_W-1:0]    div,
  input  logic [RECIP_W-1:0]  recip,
  input  lma_tag_t            s2_tag,
  input  logic [SUM_W-1:0]    s2_sum,
  output logic                out_valid,
  output logic [SAMPLE_W-1:0] out_average,
  output logic                out_last
);

  localparam int PROD_W = SUM_W + RECIP_W;
  localparam int QD_W   = SUM_W + DIV_W;

  lma_tag_t            s3_tag_r, s4_tag_r, s5_tag_r;
  logic [PROD_W-1:0]   prod_r;
  logic [SUM_W-1:0]    sum3_r, sum4_r;
  logic [SUM_W-1:0]    q4_r;
  logic [QD_W-1:0]     qd4_r;
  logic [SAMPLE_W-1:0] avg_r;

  logic [SUM_W-1:0] q_est;
  logic [SUM_W-1:0] rem;
  logic [SUM_W-1:0] q_fix;

  // estimate is floor or one below it
  assign q_est = SUM_W'(prod_r >> RECIP_SHIFT);
  assign rem   = sum4_r - SUM_W'(qd4_r);
  assign q_fix = (rem >= SUM_W'(div)) ? q4_r + SUM_W'(1) : q4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_tag_r <= '0;
      s4_tag_r <= '0;
      s5_tag_r <= '0;
    end else if (advance) begin
      s3_tag_r <= s2_tag;
      s4_tag_r <= s3_tag_r;
      s5_tag_r <= s4_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prod_r <= PROD_W'(s2_sum) * PROD_W'(recip);
      sum3_r <= s2_sum;
      q4_r   <= q_est;
      qd4_r  <= QD_W'(q_est) * QD_W'(div);
      sum4_r <= sum3_r;
      avg_r  <= q_fix[SAMPLE_W-1:0];
    end
  end

  assign out_valid   = s5_tag_r.valid;
  assign out_last    = s5_tag_r.last;
  assign out_average = avg_r;

endmodule
